>>> design/pol_pkg.sv
package pol_pkg;

  localparam int CAPACITY = 64;
  localparam int IDX_W    = $clog2(CAPACITY);
  localparam int CNT_W    = $clog2(CAPACITY + 1);
  localparam int POS_W    = 7;
  localparam int WORD_W   = 32;
  localparam int LEN_W    = 7;
  localparam int CMP_W    = (POS_W > CNT_W) ? POS_W : CNT_W;

  // read-back OR tree: leaf groups of eight cells
  localparam int GROUP_SIZE = 8;
  localparam int GROUPS     = (CAPACITY + GROUP_SIZE - 1) / GROUP_SIZE;

  typedef enum logic [1:0] {
    MODE_INSERT = 2'd0,
    MODE_REMOVE = 2'd1,
    MODE_GET    = 2'd2,
    MODE_CLEAR  = 2'd3
  } mode_t;

  typedef logic [WORD_W-1:0] word_t;

  // shift command broadcast to every cell
  typedef struct packed {
    logic             ins;
    logic             rem;
    logic [POS_W-1:0] pos;
    word_t            value;
  } cell_ctrl_t;

endpackage

>>> design/pol_req_if.sv
interface pol_req_if;
  import pol_pkg::*;

  logic             valid;
  logic             ready;
  logic [1:0]       mode;
  logic [POS_W-1:0] position;
  logic signed [WORD_W-1:0] value;

  modport source (output valid, mode, position, value, input ready);
  modport sink   (input valid, mode, position, value, output ready);
endinterface

>>> design/pol_rsp_if.sv
interface pol_rsp_if;
  import pol_pkg::*;

  logic             valid;
  logic             ready;
  logic             ok;
  logic signed [WORD_W-1:0] read_value;
  logic [LEN_W-1:0] length;
  logic             is_empty;

  modport source (output valid, ok, read_value, length, is_empty, input ready);
  modport sink   (input valid, ok, read_value, length, is_empty, output ready);
endinterface

>>> design/positional_ordered_list_unit.sv
// Pipeline: the list updates in the transfer cycle, the read-back OR tree
//   register and stage 1 capture the request, then the response register.
// Throughput: one request per cycle unless rsp stalls; a request shifts all cells.
// Reset (rst, synchronous, active high) empties the list and drops every
//   pending response; cell contents are left as they are and are never read
//   until written again.
module positional_ordered_list_unit
  import pol_pkg::*;
(
  input logic        clk,
  input logic        rst,
  pol_req_if.sink    req,
  pol_rsp_if.source  rsp
);

  // ------------------------------------------------------------------
  // List length
  // ------------------------------------------------------------------
  logic [CNT_W-1:0] count;
  logic [CNT_W-1:0] count_next;

  logic             accept;
  logic             ins_ok;
  logic             rem_ok;
  logic             get_ok;
  logic             clr_ok;
  logic             req_ok;
  logic [CMP_W-1:0] pos_c;
  logic [CMP_W-1:0] cnt_c;

  assign accept = req.valid && req.ready;
  assign pos_c  = CMP_W'(req.position);
  assign cnt_c  = CMP_W'(count);

  // Range checks: insert may land at the tail (position == count) but not
  // into a full list; remove/get need an existing entry; clear needs one too.
  always_comb begin
    ins_ok = 1'b0;
    rem_ok = 1'b0;
    get_ok = 1'b0;
    clr_ok = 1'b0;
    unique case (mode_t'(req.mode))
      MODE_INSERT: ins_ok = (pos_c <= cnt_c) && (count < CNT_W'(CAPACITY));
      MODE_REMOVE: rem_ok = pos_c < cnt_c;
      MODE_GET:    get_ok = pos_c < cnt_c;
      MODE_CLEAR:  clr_ok = count != '0;
      default:     ;
    endcase
  end

  assign req_ok = ins_ok || rem_ok || get_ok || clr_ok;

  always_comb begin
    count_next = count;
    if (accept) begin
      priority if (ins_ok) begin
        count_next = count + 1'b1;
      end else if (rem_ok) begin
        count_next = count - 1'b1;
      end else if (clr_ok) begin
        count_next = '0;
      end else begin
        count_next = count;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else begin
      count <= count_next;
    end
  end

  // ------------------------------------------------------------------
  // Cell chain: cell i takes from i-1 on insert, from i+1 on remove.
  // Ends of the chain see their own word; the stray value at the far end
  // after a remove lies beyond count and is never read.
  // ------------------------------------------------------------------
  cell_ctrl_t ctrl;
  word_t      cell_data [CAPACITY];
  word_t      cell_hit  [CAPACITY];

  assign ctrl.ins   = accept && ins_ok;
  assign ctrl.rem   = accept && rem_ok;
  assign ctrl.pos   = req.position;
  assign ctrl.value = req.value;

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    word_t left_w;
    word_t right_w;

    if (i == 0) begin : g_head
      assign left_w = cell_data[i];
    end else begin : g_mid_l
      assign left_w = cell_data[i-1];
    end

    if (i == CAPACITY - 1) begin : g_tail
      assign right_w = cell_data[i];
    end else begin : g_mid_r
      assign right_w = cell_data[i+1];
    end

    pol_cell u_cell (
      .clk      (clk),
      .idx      (IDX_W'(i)),
      .ctrl     (ctrl),
      .left     (left_w),
      .right    (right_w),
      .data     (cell_data[i]),
      .hit_data (cell_hit[i])
    );
  end

  // ------------------------------------------------------------------
  // Read-back: only the addressed cell drives nonzero; partial ORs are
  // captured with the transfer, before any shift of this request lands.
  // ------------------------------------------------------------------
  word_t tree_out;

  pol_read_tree u_tree (
    .clk    (clk),
    .load   (accept),
    .leaf   (cell_hit),
    .result (tree_out)
  );

  // ------------------------------------------------------------------
  // Stage 1: request status, waits beside the tree register
  // ------------------------------------------------------------------
  logic             s1_valid;
  logic             s1_ok;
  logic             s1_get;
  logic [CNT_W-1:0] s1_count;
  logic             out_free;
  logic             s1_move;

  assign out_free  = !rsp.valid || rsp.ready;
  assign s1_move   = s1_valid && out_free;
  assign req.ready = !s1_valid || s1_move;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (accept) begin
      s1_valid <= 1'b1;
    end else if (s1_move) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_ok    <= req_ok;
      s1_get   <= get_ok;
      s1_count <= count_next;
    end
  end

  // ------------------------------------------------------------------
  // Response register
  // ------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp.valid <= 1'b0;
    end else if (s1_move) begin
      rsp.valid <= 1'b1;
    end else if (rsp.ready) begin
      rsp.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_move) begin
      rsp.ok         <= s1_ok;
      rsp.read_value <= s1_get ? tree_out : '0;
      rsp.length     <= LEN_W'(s1_count);
      rsp.is_empty   <= s1_count == '0;
    end
  end

endmodule

>>> design/pol_cell.sv
module pol_cell
  import pol_pkg::*;
(
  input  logic             clk,
  input  logic [IDX_W-1:0] idx,
  input  cell_ctrl_t       ctrl,
  input  word_t            left,
  input  word_t            right,
  output word_t            data,
  output word_t            hit_data
);

  word_t entry;
  word_t entry_next;
  logic  at_pos;
  logic  past_pos;

  assign at_pos   = CMP_W'(idx) == CMP_W'(ctrl.pos);
  assign past_pos = CMP_W'(idx) >  CMP_W'(ctrl.pos);

  always_comb begin
    entry_next = entry;
    if (ctrl.ins && at_pos) begin
      entry_next = ctrl.value;
    end else if (ctrl.ins && past_pos) begin
      entry_next = left;
    end else if (ctrl.rem && (at_pos || past_pos)) begin
      entry_next = right;
    end
  end

  always_ff @(posedge clk) begin
    entry <= entry_next;
  end

  assign data     = entry;
  assign hit_data = at_pos ? entry : '0;

endmodule

>>> design/pol_read_tree.sv
module pol_read_tree
  import pol_pkg::*;
(
  input  logic  clk,
  input  logic  load,
  input  word_t leaf [CAPACITY],
  output word_t result
);

  word_t group_or      [GROUPS];
  word_t group_or_next [GROUPS];

  // first level: one OR of eight masked cell words per group, registered
  for (genvar g = 0; g < GROUPS; g++) begin : g_grp
    always_comb begin
      group_or_next[g] = '0;
      for (int j = 0; j < GROUP_SIZE; j++) begin
        if (g * GROUP_SIZE + j < CAPACITY) begin
          group_or_next[g] = group_or_next[g] | leaf[g * GROUP_SIZE + j];
        end
      end
    end

    always_ff @(posedge clk) begin
      if (load) begin
        group_or[g] <= group_or_next[g];
      end
    end
  end

  always_comb begin
    result = '0;
    for (int g = 0; g < GROUPS; g++) begin
      result = result | group_or[g];
    end
  end

endmodule

>>> design/pol_checker.sv
module pol_checker
  import pol_pkg::*;
(
  input logic              clk,
  input logic              rst,
  input logic              rsp_valid,
  input logic              rsp_ready,
  input logic              rsp_ok,
  input logic [WORD_W-1:0] rsp_read_value,
  input logic [LEN_W-1:0]  rsp_length,
  input logic              rsp_is_empty
);

  a_empty_flag: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> (rsp_is_empty == (rsp_length == '0)))
    else $error("empty flag disagrees with length");

  a_fail_zero: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && !rsp_ok) |-> (rsp_read_value == '0))
    else $error("refused request returned nonzero data");

  a_len_bound: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> (rsp_length <= LEN_W'(CAPACITY)))
    else $error("length beyond capacity");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(rsp_ok) &&
      $stable(rsp_read_value) && $stable(rsp_length)))
    else $error("stalled response changed");

endmodule

bind positional_ordered_list_unit pol_checker u_pol_checker (
  .clk            (clk),
  .rst            (rst),
  .rsp_valid      (rsp.valid),
  .rsp_ready      (rsp.ready),
  .rsp_ok         (rsp.ok),
  .rsp_read_value (rsp.read_value),
  .rsp_length     (rsp.length),
  .rsp_is_empty   (rsp.is_empty)
);

>>> bench/pol_list_checker.sv
module pol_list_checker
  import pol_pkg::*;
(
  input  logic clk,
  input  logic rst,
  pol_req_if   req,
  pol_rsp_if   rsp,
  output int   fail_count,
  output int   results_owed,
  output int   list_len
);

  typedef struct packed {
    logic             ok;
    word_t            read_value;
    logic [LEN_W-1:0] length;
    logic             is_empty;
  } list_rsp_t;

  word_t     cells [CAPACITY];
  int        cell_count = 0;
  int        fails = 0;
  list_rsp_t rsp_expected [$];

  assign fail_count   = fails;
  assign list_len     = cell_count;

  // Apply one request to the shadow list; returns the response it should give.
  function automatic list_rsp_t apply_request(mode_t op, logic [POS_W-1:0] pos, word_t v);
    list_rsp_t r;
    int        p;
    r = '0;
    p = pos;
    case (op)
      MODE_INSERT: begin
        if (p <= cell_count && cell_count < CAPACITY) begin
          for (int i = cell_count; i > p; i--) cells[i] = cells[i - 1];
          cells[p] = v;
          cell_count++;
          r.ok = 1'b1;
        end
      end
      MODE_REMOVE: begin
        if (p < cell_count) begin
          for (int i = p; i + 1 < cell_count; i++) cells[i] = cells[i + 1];
          cell_count--;
          r.ok = 1'b1;
        end
      end
      MODE_GET: begin
        if (p < cell_count) begin
          r.read_value = cells[p];
          r.ok         = 1'b1;
        end
      end
      default: begin
        if (cell_count > 0) begin
          cell_count = 0;
          r.ok       = 1'b1;
        end
      end
    endcase
    r.length   = LEN_W'(cell_count);
    r.is_empty = (cell_count == 0);
    return r;
  endfunction

  task automatic compare_field(string field, logic [31:0] want, logic [31:0] got);
    if (got !== want) begin
      $error("%s: expected 0x%0h, got 0x%0h", field, want, got);
      fails++;
    end
  endtask

  // Response side first: a response never belongs to a request taken at the same edge.
  always @(posedge clk) begin
    list_rsp_t want;
    if (rst) begin
      rsp_expected.delete();
      cell_count = 0;
    end else begin
      if (rsp.valid && rsp.ready) begin
        if (rsp_expected.size() == 0) begin
          $error("response with nothing outstanding: ok=%0b length=%0d", rsp.ok, rsp.length);
          fails++;
        end else begin
          want = rsp_expected.pop_front();
          compare_field("ok", want.ok, rsp.ok);
          compare_field("read_value", want.read_value, rsp.read_value);
          compare_field("length", want.length, rsp.length);
          compare_field("is_empty", want.is_empty, rsp.is_empty);
        end
      end
      if (req.valid && req.ready)
        rsp_expected.push_back(apply_request(mode_t'(req.mode), req.position, req.value));
    end
    results_owed = rsp_expected.size();
  end

endmodule

>>> bench/tb_top.sv
module tb_top;
  import pol_pkg::*;

  localparam int RANDOM_ITEMS = 750;
  localparam int HOLD_CYCLES  = 300;   // long receiver hold-off
  localparam int STALL_LIMIT  = 3000;  // cycles with no transfer before giving up
  localparam int DRAIN_CYCLES = 10;    // settle time after the last response
  localparam int POS_MAX      = (1 << POS_W) - 1;

  logic clk = 1'b0;
  logic rst = 1'b1;

  pol_req_if req ();
  pol_rsp_if rsp ();

  int fail_count;
  int results_owed;
  int list_len;      // shadow count from the checker, used to aim positions
  int items_sent = 0;
  int holds_asked = 0;
  bit no_stall = 1'b0;

  always #6 clk = ~clk;

  positional_ordered_list_unit u_top (
    .clk (clk),
    .rst (rst),
    .req (req),
    .rsp (rsp)
  );

  pol_list_checker u_check (
    .clk          (clk),
    .rst          (rst),
    .req          (req),
    .rsp          (rsp),
    .fail_count   (fail_count),
    .results_owed (results_owed),
    .list_len     (list_len)
  );

  // Biased word: extremes show up often, the rest is uniform.
  function automatic word_t rand_word();
    case ($urandom_range(0, 7))
      0: return 32'h7FFF_FFFF;
      1: return 32'h8000_0000;
      2: return '0;
      3: return '1;
      default: return $urandom;
    endcase
  endfunction

  // Called at a falling edge; returns at the falling edge after the transfer,
  // with valid still high so the next call can keep the bus busy.
  task automatic offer(mode_t m, int pos, word_t v);
    if (!no_stall && $urandom_range(0, 99) < 9) begin
      req.valid <= 1'b0;
      @(negedge clk);
    end
    req.valid    <= 1'b1;
    req.mode     <= m;
    req.position <= POS_W'(pos);
    req.value    <= v;
    @(posedge clk);
    while (!req.ready) @(posedge clk);
    @(negedge clk);
    items_sent++;
  endtask

  // Insert at random legal spots until full, then knock on the full list.
  task automatic fill_list();
    while (list_len < CAPACITY)
      offer(MODE_INSERT, $urandom_range(0, list_len), rand_word());
    repeat (2) offer(MODE_INSERT, $urandom_range(0, CAPACITY), rand_word());
  endtask

  // Sender goes quiet until every response is back.
  task automatic pause_until_drained();
    req.valid <= 1'b0;
    wait (results_owed == 0);
    @(negedge clk);
  endtask

  // Response side: random stalls, or a long hold-off when asked for.
  initial begin
    int holds_done;
    holds_done = 0;
    rsp.ready <= 1'b0;
    forever begin
      @(negedge clk);
      if (holds_asked != holds_done) begin
        holds_done = holds_asked;
        rsp.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
      end else begin
        rsp.ready <= no_stall || ($urandom_range(0, 99) >= 9);
      end
    end
  end

  // Watchdog: give up when the handshakes stop moving.
  initial begin
    int idle_cycles;
    idle_cycles = 0;
    while (idle_cycles < STALL_LIMIT) begin
      @(posedge clk);
      if (rst || (req.valid && req.ready) || (rsp.valid && rsp.ready))
        idle_cycles = 0;
      else
        idle_cycles++;
    end
    $display("tb_top failed");
    $finish;
  end

  initial begin
    int    k;
    int    n;
    int    hi;
    int    p;
    mode_t m;

    req.valid    <= 1'b0;
    req.mode     <= MODE_INSERT;
    req.position <= '0;
    req.value    <= '0;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // --- directed: refusals on an empty list
    offer(MODE_GET,    0, 32'h0);
    offer(MODE_REMOVE, 0, 32'h0);
    offer(MODE_CLEAR,  0, 32'h0);          // clear of an empty list is refused
    offer(MODE_INSERT, 1, 32'h1);          // past the end
    // build [-1, 0, MAX, MIN] through front, append and middle inserts
    offer(MODE_INSERT, 0, 32'h7FFF_FFFF);
    offer(MODE_INSERT, 1, 32'h8000_0000);
    offer(MODE_INSERT, 0, 32'hFFFF_FFFF);
    offer(MODE_INSERT, 1, 32'h0);
    offer(MODE_INSERT, POS_MAX, 32'h5);    // far out of range
    offer(MODE_GET,    0, 32'hA5A5_A5A5);  // value must not matter
    offer(MODE_GET,    3, 32'h0);
    offer(MODE_GET,    4, 32'h0);          // position == count
    offer(MODE_GET,    POS_MAX, 32'hFFFF_FFFF);
    offer(MODE_REMOVE, 4, 32'h0);
    offer(MODE_REMOVE, 1, 32'h1234_5678);  // value ignored on remove
    offer(MODE_GET,    1, 32'h0);
    offer(MODE_REMOVE, 2, 32'h0);          // last entry
    offer(MODE_REMOVE, 0, 32'h0);          // first entry
    offer(MODE_INSERT, 1, 32'h5A5A_5A5A);  // append at position == count
    offer(MODE_CLEAR,  0, 32'hFFFF_FFFF);
    offer(MODE_GET,    0, 32'h0);
    offer(MODE_REMOVE, POS_MAX, 32'h0);
    offer(MODE_CLEAR,  POS_MAX, 32'hDEAD_BEEF);

    // --- backpressure: receiver holds off while we try to fill the list,
    // so the pipeline backs up and request ready drops.
    holds_asked <= holds_asked + 1;
    fill_list();
    pause_until_drained();

    // --- random episodes
    while (items_sent < RANDOM_ITEMS) begin
      no_stall <= (items_sent >= 400 && items_sent < 520);
      case ($urandom_range(0, 19))
        0, 1: fill_list();
        2, 3: begin
          // drain by random removes, then poke the empty list
          while (list_len > 0)
            offer(MODE_REMOVE, $urandom_range(0, list_len - 1), rand_word());
          offer(mode_t'($urandom_range(1, 3)), $urandom_range(0, 3), rand_word());
        end
        4: begin
          offer(MODE_CLEAR, $urandom_range(0, POS_MAX), rand_word());
          if ($urandom_range(0, 1))
            offer(MODE_CLEAR, $urandom_range(0, POS_MAX), rand_word());
        end
        5: begin
          // raw noise over every field
          n = $urandom_range(5, 15);
          repeat (n)
            offer(mode_t'($urandom_range(0, 3)), $urandom_range(0, POS_MAX), $urandom);
        end
        6: pause_until_drained();
        default: begin
          // mostly legal traffic, with a share of boundary and stray positions
          n = $urandom_range(10, 40);
          repeat (n) begin
            k = $urandom_range(0, 99);
            if (k < 40)      m = MODE_INSERT;
            else if (k < 65) m = MODE_REMOVE;
            else if (k < 98) m = MODE_GET;
            else             m = MODE_CLEAR;
            hi = (m == MODE_INSERT) ? list_len : list_len - 1;
            if (hi < 0 || $urandom_range(0, 9) == 0)
              p = $urandom_range(0, 1) ? hi + 1 : $urandom_range(hi + 1, POS_MAX);
            else
              p = $urandom_range(0, hi);
            offer(m, p, rand_word());
          end
        end
      endcase
    end

    // --- wind down
    req.valid <= 1'b0;
    no_stall  <= 1'b0;
    wait (results_owed == 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0 && results_owed == 0)
      $display("tb_top passed");
    else
      $display("tb_top failed");
    $finish;
  end

endmodule

>>> files.f
design/pol_pkg.sv
design/pol_req_if.sv
design/pol_rsp_if.sv
design/pol_cell.sv
design/pol_read_tree.sv
design/positional_ordered_list_unit.sv
design/pol_checker.sv
bench/pol_list_checker.sv
bench/tb_top.sv
